// ----- design/twrtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire RTC access package
// Shared types, constants and BCD conversion functions for the bus master.
// ----------------------------------------------------------------------------
package twrtc_pkg;

	localparam int unsigned SetupTicks = 2;
	localparam int unsigned SetupEff   = (SetupTicks < 1) ? 1 :
		((SetupTicks > 15) ? 15 : SetupTicks);

	localparam logic [7:0] CmdLow      = 8'h80;
	localparam logic [7:0] CmdHigh     = 8'h91;
	localparam logic [7:0] MaskMinSec  = 8'h70;
	localparam logic [7:0] MaskHrDate  = 8'h30;
	localparam logic [7:0] MaskMonth   = 8'h10;
	localparam logic [7:0] MaskYear    = 8'hF0;
	localparam logic [7:0] MaskUnits   = 8'h0F;
	localparam logic [7:0] MaskWeekday = 8'h07;
	localparam logic [7:0] BadValue    = 8'hFF;

	localparam logic [3:0] RegSeconds = 4'd0;
	localparam logic [3:0] RegMinutes = 4'd1;
	localparam logic [3:0] RegHours   = 4'd2;
	localparam logic [3:0] RegDate    = 4'd3;
	localparam logic [3:0] RegMonth   = 4'd4;
	localparam logic [3:0] RegWeekday = 4'd5;
	localparam logic [3:0] RegYear    = 4'd6;
	localparam logic [3:0] RegControl = 4'd7;
	localparam logic [3:0] LastBit    = 4'd15;

	typedef enum logic [5:0] {
		PhIdle  = 6'b000001,
		PhSetup = 6'b000010,
		PhCmd   = 6'b000100,
		PhWdata = 6'b001000,
		PhRdata = 6'b010000,
		PhDone  = 6'b100000
	} twrtc_phase_t;

	typedef struct packed {
		logic       start_req;
		logic [7:0] command;
		logic [7:0] write_value;
		logic       io_sample;
	} twrtc_item_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       data_drive;
		logic       data_out;
		logic       done_res;
		logic [7:0] read_value;
		logic       bad_command;
	} twrtc_res_t;

	typedef struct packed {
		twrtc_phase_t phase;
		logic [3:0]   tick;
		logic [7:0]   shift;
		logic [7:0]   cmd;
		logic [7:0]   data;
	} twrtc_state_t;

	function automatic logic [7:0] tens_mask(input logic [3:0] reg_idx);
		logic [7:0] m;
		unique case (reg_idx)
			RegSeconds, RegMinutes: m = MaskMinSec;
			RegHours, RegDate:      m = MaskHrDate;
			RegMonth:               m = MaskMonth;
			RegYear:                m = MaskYear;
			default:                m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] to_bcd(input logic [3:0] reg_idx, input logic [7:0] v);
		logic [18:0] prod;
		logic [4:0]  quo;
		logic [7:0]  rem;
		logic [7:0]  r;
		prod = {11'd0, v} * 19'd205;
		quo  = prod[15:11];
		rem  = v - ({3'd0, quo} << 3) - ({3'd0, quo} << 1);
		if (reg_idx == RegWeekday) begin
			r = v & MaskWeekday;
		end else if (reg_idx >= RegControl) begin
			r = v;
		end else begin
			r = (({3'd0, quo} << 4) & tens_mask(reg_idx)) | (rem & MaskUnits);
		end
		return r;
	endfunction

	function automatic logic [7:0] from_bcd(input logic [3:0] reg_idx, input logic [7:0] v);
		logic [7:0] hi;
		logic [7:0] tens;
		logic [7:0] r;
		hi   = v & tens_mask(reg_idx);
		tens = {4'd0, hi[7:4]};
		if (reg_idx == RegWeekday) begin
			r = v & MaskWeekday;
		end else if (reg_idx >= RegControl) begin
			r = v;
		end else begin
			r = (v & MaskUnits) + (tens << 3) + (tens << 1);
		end
		return r;
	endfunction

endpackage

// ----- design/twrtc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire RTC request channel
// Valid/ready channel that carries one half-bit tick request.
// ----------------------------------------------------------------------------
interface twrtc_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] command;
	logic [7:0] write_value;
	logic       io_sample;

	modport source (output valid, start_req, command, write_value, io_sample, input ready);
	modport sink (input valid, start_req, command, write_value, io_sample, output ready);
endinterface

// ----- design/twrtc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire RTC result channel
// Valid/ready channel that carries the bus levels and status of one tick.
// ----------------------------------------------------------------------------
interface twrtc_out_if;
	logic       valid;
	logic       ready;
	logic       chip_enable;
	logic       serial_clock;
	logic       data_drive;
	logic       data_out;
	logic       done_res;
	logic [7:0] read_value;
	logic       bad_command;

	modport source (output valid, chip_enable, serial_clock, data_drive, data_out,
		done_res, read_value, bad_command, input ready);
	modport sink (input valid, chip_enable, serial_clock, data_drive, data_out,
		done_res, read_value, bad_command, output ready);
endinterface

// ----- design/twrtc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire RTC tick step
// Next-state and bus-level logic for one half-bit tick of the transaction.
// ----------------------------------------------------------------------------
module twrtc_step
	import twrtc_pkg::*;
(
	input  twrtc_state_t st,
	input  twrtc_item_t  item,
	output twrtc_state_t nxt,
	output twrtc_res_t   res
);

	logic [4:0] tick_inc;

	assign tick_inc = {1'b0, st.tick} + 5'd1;

	always_comb begin
		nxt = st;
		res = '0;
		unique case (st.phase)
			PhIdle: begin
				if (item.start_req) begin
					if (item.command < CmdLow || item.command > CmdHigh) begin
						res.done_res    = 1'b1;
						res.bad_command = 1'b1;
						res.read_value  = BadValue;
					end else begin
						nxt.cmd         = item.command;
						nxt.data        = to_bcd(item.command[4:1], item.write_value);
						nxt.shift       = item.command;
						nxt.tick        = 4'd0;
						nxt.phase       = PhSetup;
						res.chip_enable = 1'b1;
					end
				end
			end
			PhSetup: begin
				res.chip_enable = 1'b1;
				if (tick_inc >= SetupEff[4:0]) begin
					nxt.tick  = 4'd0;
					nxt.phase = PhCmd;
				end else begin
					nxt.tick = tick_inc[3:0];
				end
			end
			PhCmd, PhWdata: begin
				res.chip_enable  = 1'b1;
				res.data_drive   = 1'b1;
				res.data_out     = st.shift[0];
				res.serial_clock = st.tick[0];
				if (st.tick[0]) begin
					nxt.shift = {1'b0, st.shift[7:1]};
				end
				if (st.tick == LastBit) begin
					nxt.tick = 4'd0;
					if (st.phase == PhCmd && !st.cmd[0]) begin
						nxt.phase = PhWdata;
						nxt.shift = st.data;
					end else if (st.phase == PhCmd) begin
						nxt.phase = PhRdata;
						nxt.shift = 8'd0;
					end else begin
						nxt.phase = PhDone;
					end
				end else begin
					nxt.tick = tick_inc[3:0];
				end
			end
			PhRdata: begin
				res.chip_enable  = 1'b1;
				res.serial_clock = ~st.tick[0];
				if (st.tick[0]) begin
					nxt.shift = {item.io_sample, st.shift[7:1]};
				end
				if (st.tick == LastBit) begin
					nxt.tick  = 4'd0;
					nxt.phase = PhDone;
				end else begin
					nxt.tick = tick_inc[3:0];
				end
			end
			default: begin
				res.done_res   = 1'b1;
				res.read_value = st.cmd[0] ? from_bcd(st.cmd[4:1], st.shift) : 8'd0;
				nxt.tick       = 4'd0;
				nxt.phase      = PhIdle;
			end
		endcase
	end

endmodule

// ----- design/three_wire_rtc_register_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire RTC register access master
// Validates a register command, then drives enable, clock and data for one
// command byte and one BCD data byte, one half-bit tick per request.
//
// Channel  Dir  Payload
// in_ch    in   start_req, command, write_value, io_sample
// out_ch   out  chip_enable, serial_clock, data_drive, data_out, done_res,
//               read_value, bad_command
//
// Each request yields one result, held first in the input register and then
// in the result register.
// A new request is accepted every cycle while results are being taken.
// A stalled result holds the result register, and one more request waits in
// the input register before ready drops.
// Reset returns the bus sequencer to idle with all counters cleared.
// ----------------------------------------------------------------------------
module three_wire_rtc_register_access
	import twrtc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	twrtc_in_if.sink      in_ch,
	twrtc_out_if.source   out_ch
);

	logic         valid_s1;
	twrtc_item_t  item_s1;
	logic         valid_s2;
	twrtc_res_t   res_s2;
	twrtc_state_t state_q;
	twrtc_state_t state_nxt;
	twrtc_res_t   res_nxt;
	logic         advance;

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= '{start_req: in_ch.start_req, command: in_ch.command,
				write_value: in_ch.write_value, io_sample: in_ch.io_sample};
		end
	end

	twrtc_step u_step (
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PhIdle, tick: 4'd0, shift: 8'd0, cmd: 8'd0, data: 8'd0};
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.chip_enable  = res_s2.chip_enable;
	assign out_ch.serial_clock = res_s2.serial_clock;
	assign out_ch.data_drive   = res_s2.data_drive;
	assign out_ch.data_out     = res_s2.data_out;
	assign out_ch.done_res     = res_s2.done_res;
	assign out_ch.read_value   = res_s2.read_value;
	assign out_ch.bad_command  = res_s2.bad_command;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ch.ready)
		else $error("Request stalled while the result register is empty.");

	a_idle_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PhIdle |-> state_q.tick == 4'd0)
		else $error("Tick counter not clear in idle.");

	a_bad_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.bad_command) |->
		(res_s2.done_res && res_s2.read_value == BadValue && !res_s2.chip_enable))
		else $error("Rejected command result is malformed.");

	a_drive_only_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.phase == PhRdata) |=> (valid_s2 && !res_s2.data_drive))
		else $error("Data pin driven during a read.");

endmodule
